// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the data string processor RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("assertion failed");

// The expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, ck, rn, expr) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (expr)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLY(lbl, ck, rn, ante, cons)
`define ASSERT_NEXT(lbl, ck, rn, ante, cons)
`define ASSERT_ALWAYS(lbl, ck, rn, expr)

`endif

`endif

// ----- hw/rtl/pds_pkg.sv -----
// ---------------------------------------------------------------------------
// Data string processor package
// Beat types, result kinds, opcodes and the job descriptor passed from the
// front end to the back end.
// ---------------------------------------------------------------------------
package pds_pkg;

  // Default return stack depth.
  localparam int STACK_DEPTH_DEF = 8;

  // Entries in the job queue between front and back end.
  localparam int QUEUE_DEPTH = 4;

  // Width of a repeat count (1 to 64).
  localparam int CNT_W = 7;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_START_ADDRESS   = 1'b0;
  localparam logic REG_INITIAL_CONTROL = 1'b1;

  // Opcodes and control byte fields.
  localparam logic [7:0] OP_END_MIN      = 8'h80;
  localparam logic [7:0] OP_CALL         = 8'h4C;
  localparam logic [7:0] OP_RETURN       = 8'h60;
  localparam logic [7:0] CTRL_COUNT_MASK = 8'h3F;
  localparam logic [7:0] CTRL_FILL_BIT   = 8'h40;
  localparam logic [7:0] SHADOW_INC_SET  = 8'h04;
  localparam logic [7:0] SHADOW_INC_CLR  = 8'hFB;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(64);

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_NONE      = 3'd0,
    KIND_CONTROL   = 3'd1,
    KIND_ADDR_HIGH = 3'd2,
    KIND_ADDR_LOW  = 3'd3,
    KIND_DATA      = 3'd4,
    KIND_RETURN    = 3'd5,
    KIND_END       = 3'd6,
    KIND_STACK_ERR = 3'd7
  } kind_t;

  // Input beat.
  typedef struct packed {
    logic       start_req;
    logic [7:0] fetched_byte;
  } in_item_t;

  // Result beat.
  typedef struct packed {
    kind_t       kind;
    logic [15:0] value;
    logic        fetch_valid;
    logic [15:0] fetch_address;
    logic        toggle_reset;
    logic        last;
  } out_item_t;

  // How the back end expands a job.
  typedef enum logic {
    JOB_REPEAT = 1'b0,
    JOB_TRIPLE = 1'b1
  } job_op_t;

  // One job: a run of identical results, or the control/address triple.
  typedef struct packed {
    job_op_t          op;
    kind_t            kind;
    logic [15:0]      value;
    logic [7:0]       ext;
    logic [CNT_W-1:0] count;
    logic             fetch_valid;
    logic [15:0]      fetch_address;
    logic             toggle_reset;
  } job_t;

endpackage

// ----- hw/rtl/pds_ram.sv -----
// ---------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ---------------------------------------------------------------------------
module pds_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/pds_queue.sv -----
// ---------------------------------------------------------------------------
// Job queue
// Small first-in first-out buffer of job descriptors between the front end
// and the back end.
// ---------------------------------------------------------------------------
module pds_queue
  import pds_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  job_t          entry_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  assign pop_job = entry_r[rd_ptr_r];
  assign full    = (count_r == CW'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);

endmodule

// ----- hw/rtl/pds_front.sv -----
// ---------------------------------------------------------------------------
// Front end
// Takes program bytes, walks the opcode state machine, keeps the read
// pointer, control shadow and return stack, and issues one job per byte.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pds_front
  import pds_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] cfg_start_address,
  input  logic [7:0]  cfg_initial_control,
  input  logic        in_valid,
  input  in_item_t    in_data,
  output logic        in_ready,
  output logic        push,
  output job_t        push_job,
  input  logic        q_full
);

  localparam int IDXW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SCW  = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_OPCODE  = 3'd1,
    PH_CALL_LO = 3'd2,
    PH_CALL_HI = 3'd3,
    PH_DEST_LO = 3'd4,
    PH_CONTROL = 3'd5,
    PH_DATA    = 3'd6
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [15:0]      read_pointer_r, read_pointer_nxt;
  logic [6:0]       address_high_r, address_high_nxt;
  logic [7:0]       address_low_r, address_low_nxt;
  logic [CNT_W-1:0] bytes_left_r, bytes_left_nxt;
  logic             fill_mode_r, fill_mode_nxt;
  logic [7:0]       control_shadow_r, control_shadow_nxt;
  logic [SCW-1:0]   stack_count_r, stack_count_nxt;
  logic             pop_wait_r, pop_wait_nxt;

  logic             accept;
  logic [7:0]       b;
  logic [7:0]       ctrl_new;
  logic [CNT_W-1:0] run_len;
  logic [CNT_W-1:0] ctrl_len;
  logic [SCW-1:0]   top_slot;
  logic             stk_wr_en;
  logic [15:0]      stk_wr_data;
  logic [15:0]      stk_rd_data;
  job_t             job;

  assign in_ready = !pop_wait_r && !q_full;
  assign accept   = in_valid && in_ready;
  assign b        = in_data.fetched_byte;
  assign top_slot = stack_count_r - SCW'(1);

  // Return stack: pushed on a call, top entry read continuously.
  pds_ram #(
    .WIDTH (16),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (stk_wr_en),
    .wr_addr (stack_count_r[IDXW-1:0]),
    .wr_data (stk_wr_data),
    .rd_addr (top_slot[IDXW-1:0]),
    .rd_data (stk_rd_data)
  );

  // Control byte decoding.
  always_comb begin
    ctrl_new = b[7] ? (control_shadow_r | SHADOW_INC_SET)
                    : (control_shadow_r & SHADOW_INC_CLR);
    ctrl_len = CNT_W'(b & CTRL_COUNT_MASK);
    if (ctrl_len == '0) begin
      ctrl_len = FULL_COUNT;
    end
    run_len = bytes_left_r;
    if (bytes_left_r == '0 || bytes_left_r > FULL_COUNT) begin
      run_len = FULL_COUNT;
    end
  end

  // Next state and job for the accepted byte.
  always_comb begin
    phase_nxt          = phase_r;
    read_pointer_nxt   = read_pointer_r;
    address_high_nxt   = address_high_r;
    address_low_nxt    = address_low_r;
    bytes_left_nxt     = bytes_left_r;
    fill_mode_nxt      = fill_mode_r;
    control_shadow_nxt = control_shadow_r;
    stack_count_nxt    = stack_count_r;
    pop_wait_nxt       = pop_wait_r;
    stk_wr_en          = 1'b0;
    stk_wr_data        = read_pointer_r + 16'd1;
    push               = 1'b0;
    job                = '0;
    job.op             = JOB_REPEAT;
    job.kind           = KIND_NONE;
    job.count          = CNT_W'(1);

    if (pop_wait_r) begin
      // The popped return address is now out of the stack RAM.
      if (!q_full) begin
        read_pointer_nxt = stk_rd_data;
        job.kind         = KIND_RETURN;
        job.value        = stk_rd_data;
        pop_wait_nxt     = 1'b0;
        push             = 1'b1;
      end
    end else if (accept) begin
      push = 1'b1;
      if (in_data.start_req) begin
        read_pointer_nxt   = cfg_start_address;
        control_shadow_nxt = cfg_initial_control;
        stack_count_nxt    = '0;
        bytes_left_nxt     = '0;
        fill_mode_nxt      = 1'b0;
        phase_nxt          = PH_OPCODE;
      end else begin
        case (phase_r)
          PH_OPCODE: begin
            read_pointer_nxt = read_pointer_r + 16'd1;
            if (b >= OP_END_MIN) begin
              phase_nxt = PH_IDLE;
              job.kind  = KIND_END;
            end else if (b == OP_CALL) begin
              phase_nxt = PH_CALL_LO;
            end else if (b == OP_RETURN) begin
              if (stack_count_r == '0) begin
                phase_nxt = PH_IDLE;
                job.kind  = KIND_STACK_ERR;
              end else begin
                // The job goes out once the RAM read is back and the queue has room.
                stack_count_nxt = stack_count_r - SCW'(1);
                pop_wait_nxt    = 1'b1;
                push            = 1'b0;
              end
            end else begin
              address_high_nxt = b[6:0];
              phase_nxt        = PH_DEST_LO;
            end
          end
          PH_CALL_LO: begin
            address_low_nxt  = b;
            read_pointer_nxt = read_pointer_r + 16'd1;
            phase_nxt        = PH_CALL_HI;
          end
          PH_CALL_HI: begin
            // A push onto a full stack is dropped; the jump still happens.
            if (stack_count_r < SCW'(STACK_DEPTH)) begin
              stk_wr_en       = 1'b1;
              stack_count_nxt = stack_count_r + SCW'(1);
            end
            read_pointer_nxt = {b, address_low_r};
            phase_nxt        = PH_OPCODE;
          end
          PH_DEST_LO: begin
            address_low_nxt  = b;
            read_pointer_nxt = read_pointer_r + 16'd1;
            phase_nxt        = PH_CONTROL;
          end
          PH_CONTROL: begin
            read_pointer_nxt   = read_pointer_r + 16'd1;
            bytes_left_nxt     = ctrl_len;
            fill_mode_nxt      = |(b & CTRL_FILL_BIT);
            control_shadow_nxt = ctrl_new;
            phase_nxt          = PH_DATA;
            job.op             = JOB_TRIPLE;
            job.kind           = KIND_CONTROL;
            job.value          = {1'b0, address_high_r, ctrl_new};
            job.ext            = address_low_r;
            job.count          = CNT_W'(3);
          end
          PH_DATA: begin
            read_pointer_nxt = read_pointer_r + 16'd1;
            job.kind         = KIND_DATA;
            job.value        = {8'h00, b};
            if (fill_mode_r) begin
              job.count      = run_len;
              bytes_left_nxt = '0;
              phase_nxt      = PH_OPCODE;
            end else begin
              bytes_left_nxt = run_len - CNT_W'(1);
              if (run_len == CNT_W'(1)) begin
                phase_nxt = PH_OPCODE;
              end
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end

    // Fetch request as left by this byte.
    job.fetch_valid   = (phase_nxt != PH_IDLE);
    job.fetch_address = (phase_nxt != PH_IDLE) ? read_pointer_nxt : 16'h0000;
    job.toggle_reset  = (phase_nxt == PH_OPCODE);
  end

  assign push_job = job;

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_IDLE;
      read_pointer_r   <= '0;
      address_high_r   <= '0;
      address_low_r    <= '0;
      bytes_left_r     <= '0;
      fill_mode_r      <= 1'b0;
      control_shadow_r <= '0;
      stack_count_r    <= '0;
      pop_wait_r       <= 1'b0;
    end else begin
      phase_r          <= phase_nxt;
      read_pointer_r   <= read_pointer_nxt;
      address_high_r   <= address_high_nxt;
      address_low_r    <= address_low_nxt;
      bytes_left_r     <= bytes_left_nxt;
      fill_mode_r      <= fill_mode_nxt;
      control_shadow_r <= control_shadow_nxt;
      stack_count_r    <= stack_count_nxt;
      pop_wait_r       <= pop_wait_nxt;
    end
  end

  // The stack never holds more entries than it has room for.
  `ASSERT_ALWAYS(a_stack_bound, clk, rst_n, stack_count_r <= SCW'(STACK_DEPTH))
  // A pending return is only ever waited for from the opcode phase.
  `ASSERT_IMPLY(a_pop_phase, clk, rst_n, pop_wait_r, phase_r == PH_OPCODE)
  // A return that starts a pop delivers its job on the very next cycle unless stalled.
  `ASSERT_NEXT(a_pop_done, clk, rst_n, pop_wait_r && !q_full, !pop_wait_r)
  // No job is pushed into a full queue.
  `ASSERT_IMPLY(a_no_overflow, clk, rst_n, push, !q_full)

endmodule

// ----- hw/rtl/pds_back.sv -----
// ---------------------------------------------------------------------------
// Back end
// Expands queued jobs into result beats, one per cycle while the output is
// not stalled, into a registered output stage.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pds_back
  import pds_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  job_t      q_job,
  input  logic      q_empty,
  output logic      q_pop,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      out_ready
);

  job_t             job_r, job_nxt;
  logic             job_valid_r, job_valid_nxt;
  logic [CNT_W-1:0] seq_r, seq_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic      out_free;
  logic      emit;
  logic      is_last;
  logic      job_done;
  out_item_t res;

  assign out_free = !out_valid_r || out_ready;
  assign emit     = job_valid_r && out_free;
  assign is_last  = (seq_r == job_r.count - CNT_W'(1));
  assign job_done = emit && is_last;
  assign q_pop    = !q_empty && (!job_valid_r || job_done);

  // Result beat for the current position within the job.
  always_comb begin
    res               = '0;
    res.kind          = job_r.kind;
    res.value         = job_r.value;
    res.fetch_valid   = job_r.fetch_valid;
    res.fetch_address = job_r.fetch_address;
    res.toggle_reset  = job_r.toggle_reset;
    res.last          = is_last;
    if (job_r.op == JOB_TRIPLE) begin
      case (seq_r)
        CNT_W'(0): begin
          res.kind  = KIND_CONTROL;
          res.value = {8'h00, job_r.value[7:0]};
        end
        CNT_W'(1): begin
          res.kind  = KIND_ADDR_HIGH;
          res.value = {8'h00, job_r.value[15:8]};
        end
        default: begin
          res.kind  = KIND_ADDR_LOW;
          res.value = {8'h00, job_r.ext};
        end
      endcase
    end
  end

  // Job sequencing and output stage.
  always_comb begin
    job_nxt       = job_r;
    job_valid_nxt = job_valid_r;
    seq_nxt       = seq_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (q_pop) begin
      job_nxt       = q_job;
      job_valid_nxt = 1'b1;
      seq_nxt       = '0;
    end else if (job_done) begin
      job_valid_nxt = 1'b0;
    end else if (emit) begin
      seq_nxt = seq_r + CNT_W'(1);
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      seq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      job_valid_r <= job_valid_nxt;
      seq_r       <= seq_nxt;
      out_valid_r <= out_valid_nxt;
    end
    job_r      <= job_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The position never runs past the end of the job.
  `ASSERT_IMPLY(a_seq_bound, clk, rst_n, job_valid_r, seq_r < job_r.count)
  // A job is never taken from an empty queue.
  `ASSERT_IMPLY(a_no_underflow, clk, rst_n, q_pop, !q_empty)
  // Results of kind none, end and stack error stand alone.
  `ASSERT_IMPLY(a_single_last, clk, rst_n,
                out_valid_r && (out_data_r.kind == KIND_NONE ||
                out_data_r.kind == KIND_END || out_data_r.kind == KIND_STACK_ERR),
                out_data_r.last)

endmodule

// ----- hw/rtl/ppu_data_string_processor.sv -----
// ---------------------------------------------------------------------------
// Video-memory data string processor
// Interprets a byte-coded program of moves, fills, calls and returns and
// emits video register writes with the next fetch request.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Beat
//   in_      input      in_valid / in_ready    one fetched program byte
//   out_     output     out_valid / out_ready  one register write or status
//   cfg      input      psel/penable/pwrite    32-bit APB register access
//
// A program byte is taken every cycle while the job queue has room; a return
// opcode holds the input until the stack RAM's registered read is back.
// A byte's first result passes the job queue, job register and output register.
// Results leave at one beat per cycle unless the output stalls; a fill emits
// up to 64 beats, drained from a four-entry job queue, so the front end runs
// ahead of the back end. Reset is synchronous and needs no clearing pass: the
// return stack is only used below its fill count. A stalled output holds the
// back end, and the input as well once the job queue is full.
// ---------------------------------------------------------------------------
module ppu_data_string_processor
  import pds_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel
  input  logic                  in_valid,
  input  in_item_t              in_data,
  output logic                  in_ready,
  // Result channel
  output logic                  out_valid,
  output out_item_t             out_data,
  input  logic                  out_ready,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [15:0] start_address_r;
  logic [7:0]  initial_control_r;
  logic        cfg_write;
  logic        reg_idx;

  logic push;
  job_t push_job;
  logic q_full;
  logic q_pop;
  job_t q_job;
  logic q_empty;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_idx   = paddr[2];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_address_r   <= '0;
      initial_control_r <= '0;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_START_ADDRESS:   start_address_r   <= pwdata[15:0];
        REG_INITIAL_CONTROL: initial_control_r <= pwdata[7:0];
        default:             start_address_r   <= start_address_r;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      REG_START_ADDRESS:   prdata = {16'h0000, start_address_r};
      REG_INITIAL_CONTROL: prdata = {24'h000000, initial_control_r};
      default:             prdata = '0;
    endcase
  end

  pds_front #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_start_address   (start_address_r),
    .cfg_initial_control (initial_control_r),
    .in_valid            (in_valid),
    .in_data             (in_data),
    .in_ready            (in_ready),
    .push                (push),
    .push_job            (push_job),
    .q_full              (q_full)
  );

  pds_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (q_job),
    .empty    (q_empty)
  );

  pds_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_job     (q_job),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_ready (out_ready)
  );

endmodule
